// ===== hdl/qmm_pkg.sv =====
// Shared types, constants and arithmetic helpers for the quad motor mixer.
package qmm_pkg;

    localparam int unsigned SPEED_W = 11;
    localparam int unsigned STICK_W = 8;
    localparam int unsigned DEFL_W  = 9;
    localparam int unsigned MIN_W   = 9;
    localparam int unsigned SHIFT_W = 3;
    localparam int unsigned COUNT_W = 3;

    localparam logic [STICK_W-1:0] C_STICK_CENTRE    = 8'd127;
    localparam logic [MIN_W-1:0]   C_FLOOR_SPEED_RST = 9'd180;
    localparam logic [SHIFT_W-1:0] C_SHIFT_RST       = 3'd0;

    localparam logic KIND_MANUAL = 1'b0;
    localparam logic KIND_RAMP   = 1'b1;

    typedef enum logic [0:0] {
        CFG_FLOOR_SPEED = 1'b0,
        CFG_STICK_SHIFT = 1'b1
    } t_cfg_index;

    typedef struct packed {
        logic               kind;
        logic [STICK_W-1:0] lift;
        logic [STICK_W-1:0] pitch;
        logic [STICK_W-1:0] roll;
        logic [STICK_W-1:0] yaw;
        logic [SPEED_W-1:0] ramp_amount;
    } t_mix_in;

    typedef struct packed {
        logic [SPEED_W-1:0] motor_front;
        logic [SPEED_W-1:0] motor_right;
        logic [SPEED_W-1:0] motor_back;
        logic [SPEED_W-1:0] motor_left;
        logic [COUNT_W-1:0] running_count;
    } t_mix_out;

    // Saturating subtract, stops at zero.
    function automatic logic [SPEED_W-1:0] f_sat_sub(input logic [SPEED_W-1:0] a,
                                                     input logic [SPEED_W-1:0] b);
        return (a < b) ? '0 : a - b;
    endfunction

    // Magnitude of the doubled stick deflection after the sensitivity shift.
    function automatic logic [DEFL_W-1:0] f_deflect(input logic [STICK_W-1:0] v,
                                                    input logic [SHIFT_W-1:0] sh);
        logic [DEFL_W-1:0] mag;
        if (v > C_STICK_CENTRE) begin
            mag = {v - C_STICK_CENTRE, 1'b0};
        end else begin
            mag = {C_STICK_CENTRE - v, 1'b0};
        end
        return mag >> sh;
    endfunction

    // Add d to x, or take it away stopping at zero.
    function automatic logic [SPEED_W-1:0] f_apply(input logic [SPEED_W-1:0] x,
                                                   input logic [DEFL_W-1:0]  d,
                                                   input logic               add);
        logic [SPEED_W-1:0] dx;
        dx = SPEED_W'(d);
        return add ? x + dx : f_sat_sub(x, dx);
    endfunction

endpackage

// ===== hdl/qmm_mixer.sv =====
// Combinational mixing of one command into the four motor speeds.
module qmm_mixer (
    input  qmm_pkg::t_mix_in          i_item,
    input  qmm_pkg::t_mix_out         i_state,
    input  logic [qmm_pkg::MIN_W-1:0]   i_floor_speed,
    input  logic [qmm_pkg::SHIFT_W-1:0] i_stick_shift,
    output qmm_pkg::t_mix_out         o_result
);
    import qmm_pkg::*;

    logic [DEFL_W-1:0]  d_pitch;
    logic [DEFL_W-1:0]  d_roll;
    logic [DEFL_W-1:0]  d_yaw;
    logic               pitch_pos;
    logic               roll_pos;
    logic               yaw_pos;
    logic [SPEED_W-1:0] base;
    logic [SPEED_W-1:0] min_ext;
    logic [SPEED_W-1:0] m_front;
    logic [SPEED_W-1:0] m_right;
    logic [SPEED_W-1:0] m_back;
    logic [SPEED_W-1:0] m_left;
    logic [SPEED_W-1:0] speed [4];

    always_comb begin
        d_pitch   = f_deflect(i_item.pitch, i_stick_shift);
        d_roll    = f_deflect(i_item.roll, i_stick_shift);
        d_yaw     = f_deflect(i_item.yaw, i_stick_shift);
        pitch_pos = i_item.pitch > C_STICK_CENTRE;
        roll_pos  = i_item.roll > C_STICK_CENTRE;
        yaw_pos   = i_item.yaw > C_STICK_CENTRE;
        min_ext   = SPEED_W'(i_floor_speed);
        base      = SPEED_W'(i_item.lift) + min_ext;

        // pitch then yaw on front/back, yaw then roll on right/left
        m_front = f_apply(f_apply(base, d_pitch, pitch_pos), d_yaw, yaw_pos);
        m_back  = f_apply(f_apply(base, d_pitch, !pitch_pos), d_yaw, yaw_pos);
        m_right = f_apply(f_apply(base, d_yaw, !yaw_pos), d_roll, roll_pos);
        m_left  = f_apply(f_apply(base, d_yaw, !yaw_pos), d_roll, !roll_pos);

        if (i_item.kind == KIND_RAMP) begin
            speed[0] = f_sat_sub(i_state.motor_front, i_item.ramp_amount);
            speed[1] = f_sat_sub(i_state.motor_right, i_item.ramp_amount);
            speed[2] = f_sat_sub(i_state.motor_back, i_item.ramp_amount);
            speed[3] = f_sat_sub(i_state.motor_left, i_item.ramp_amount);
        end else if (i_item.lift == '0) begin
            speed[0] = '0;
            speed[1] = '0;
            speed[2] = '0;
            speed[3] = '0;
        end else begin
            speed[0] = (m_front < min_ext) ? min_ext : m_front;
            speed[1] = (m_right < min_ext) ? min_ext : m_right;
            speed[2] = (m_back < min_ext) ? min_ext : m_back;
            speed[3] = (m_left < min_ext) ? min_ext : m_left;
        end

        o_result.motor_front   = speed[0];
        o_result.motor_right   = speed[1];
        o_result.motor_back    = speed[2];
        o_result.motor_left    = speed[3];
        o_result.running_count = COUNT_W'(speed[0] != '0) + COUNT_W'(speed[1] != '0)
                               + COUNT_W'(speed[2] != '0) + COUNT_W'(speed[3] != '0);
    end

endmodule

// ===== hdl/quad_motor_mixer_top.sv =====
// Quad motor mixer: input register, mixing logic and result register that also holds the speeds.
// The block takes one command per clock while o_in_stall is low. An accepted command sits in
// the input register until it can advance, then passes through the mixing logic into the result
// register, which offers its result. The result register also holds the four motor speeds that
// a ramp-down command works from. A manual command sets all motors from lift plus the floor
// speed, applies pitch, yaw and roll with stopping at zero on every subtraction, then clamps to
// the floor speed (or to zero when lift is zero). A result waiting under stall holds the pipe;
// the input stalls only when both stages are full and the result is stalled.
// Write the floor speed (index 0) and stick_shift (index 1) only while no command is in flight.
module quad_motor_mixer_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  qmm_pkg::t_mix_in            i_in_data,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output qmm_pkg::t_mix_out           o_out_data,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic [0:0]                  i_cfg_index,
    input  logic [qmm_pkg::MIN_W-1:0]   i_cfg_data
);
    import qmm_pkg::*;

    logic                r_in_valid;
    t_mix_in             r_in;
    logic                r_out_valid;
    t_mix_out            r_out;
    logic [MIN_W-1:0]    r_floor_speed;
    logic [SHIFT_W-1:0]  r_stick_shift;

    logic                n_in_valid;
    logic                n_out_valid;
    t_mix_out            n_out;
    logic                advance;
    logic                in_beat;

    assign advance     = r_in_valid && (!r_out_valid || !i_out_stall);
    assign o_in_stall  = r_in_valid && !advance;
    assign in_beat     = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    qmm_mixer u_mixer (
        .i_item        (r_in),
        .i_state       (r_out),
        .i_floor_speed (r_floor_speed),
        .i_stick_shift (r_stick_shift),
        .o_result      (n_out)
    );

    always_comb begin
        if (in_beat) begin
            n_in_valid = 1'b1;
        end else if (advance) begin
            n_in_valid = 1'b0;
        end else begin
            n_in_valid = r_in_valid;
        end
        if (advance) begin
            n_out_valid = 1'b1;
        end else if (!i_out_stall) begin
            n_out_valid = 1'b0;
        end else begin
            n_out_valid = r_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid    <= 1'b0;
            r_out_valid   <= 1'b0;
            r_out         <= '0;
            r_floor_speed <= C_FLOOR_SPEED_RST;
            r_stick_shift <= C_SHIFT_RST;
        end else begin
            r_in_valid  <= n_in_valid;
            r_out_valid <= n_out_valid;
            // result register doubles as the motor speed state
            if (advance) begin
                r_out <= n_out;
            end
            if (i_cfg_valid && o_cfg_ready) begin
                unique case (t_cfg_index'(i_cfg_index))
                    CFG_FLOOR_SPEED: r_floor_speed <= i_cfg_data;
                    CFG_STICK_SHIFT: r_stick_shift <= i_cfg_data[SHIFT_W-1:0];
                    default:         r_floor_speed <= r_floor_speed;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_beat) begin
            r_in <= i_in_data;
        end
    end

    a_count_matches: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out.running_count == COUNT_W'(r_out.motor_front != '0)
                             + COUNT_W'(r_out.motor_right != '0)
                             + COUNT_W'(r_out.motor_back != '0)
                             + COUNT_W'(r_out.motor_left != '0))
        else $error("running count disagrees with motor speeds");

    a_lift_floor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.kind == KIND_MANUAL && r_in.lift != '0 |=>
            r_out.motor_front >= SPEED_W'($past(r_floor_speed)) &&
            r_out.motor_right >= SPEED_W'($past(r_floor_speed)) &&
            r_out.motor_back >= SPEED_W'($past(r_floor_speed)) &&
            r_out.motor_left >= SPEED_W'($past(r_floor_speed)))
        else $error("motor below minimum speed with lift applied");

    a_lift_off: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.kind == KIND_MANUAL && r_in.lift == '0 |=>
            r_out == '0)
        else $error("motors running with lift at zero");

    a_ramp_down: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance && r_in.kind == KIND_RAMP |=>
            r_out.motor_front <= $past(r_out.motor_front) &&
            r_out.motor_right <= $past(r_out.motor_right) &&
            r_out.motor_back <= $past(r_out.motor_back) &&
            r_out.motor_left <= $past(r_out.motor_left))
        else $error("ramp-down raised a motor speed");

endmodule

// ===== sim/quad_motor_mixer_top_tb.sv =====
// Self-checking testbench for the quad motor mixer: random stick and ramp beats vs. a predictor.
`timescale 1ns / 100ps

module quad_motor_mixer_top_tb;
    import qmm_pkg::*;

    class motor_speed_predictor;
        logic [SPEED_W-1:0] speeds [4];
        logic [MIN_W-1:0]   floor_speed;
        logic [SHIFT_W-1:0] stick_shift;
        t_mix_out           expected_speeds [$];
        int                 errors;

        function void clear();
            for (int i = 0; i < 4; i++) speeds[i] = '0;
            floor_speed = C_FLOOR_SPEED_RST;
            stick_shift = C_SHIFT_RST;
            expected_speeds.delete();
            errors = 0;
        endfunction

        function void set_register(t_cfg_index idx, logic [MIN_W-1:0] val);
            case (idx)
                CFG_FLOOR_SPEED: floor_speed = val;
                CFG_STICK_SHIFT: stick_shift = val[SHIFT_W-1:0];
                default: ;
            endcase
        endfunction

        function int pending();
            return expected_speeds.size();
        endfunction

        // Push one stick onto a motor pair: raise a and lower b above centre, the reverse below.
        function void push_stick(logic [STICK_W-1:0] v, int a, int b);
            int unsigned offs;
            int unsigned d;
            int          up_m;
            int          dn_m;
            if (v == C_STICK_CENTRE) return;
            offs = (v > C_STICK_CENTRE) ? v - C_STICK_CENTRE : C_STICK_CENTRE - v;
            d    = (2 * offs) >> stick_shift;
            up_m = (v > C_STICK_CENTRE) ? a : b;
            dn_m = (v > C_STICK_CENTRE) ? b : a;
            speeds[up_m] = SPEED_W'(speeds[up_m] + d);
            speeds[dn_m] = (speeds[dn_m] < d) ? '0 : SPEED_W'(speeds[dn_m] - d);
        endfunction

        function void take_command(t_mix_in c);
            t_mix_out r;
            int       cnt;
            if (c.kind == KIND_MANUAL) begin
                for (int i = 0; i < 4; i++)
                    speeds[i] = (c.lift != 0) ? SPEED_W'(c.lift) + SPEED_W'(floor_speed) : '0;
                push_stick(c.pitch, 0, 2);
                push_stick(c.yaw, 0, 1);
                push_stick(c.yaw, 2, 3);
                push_stick(c.roll, 1, 3);
                for (int i = 0; i < 4; i++) begin
                    if (c.lift == 0) speeds[i] = '0;
                    else if (speeds[i] < floor_speed) speeds[i] = floor_speed;
                end
            end else begin
                for (int i = 0; i < 4; i++)
                    speeds[i] = (speeds[i] < c.ramp_amount) ? '0 : speeds[i] - c.ramp_amount;
            end
            cnt = 0;
            for (int i = 0; i < 4; i++) if (speeds[i] != 0) cnt++;
            r.motor_front   = speeds[0];
            r.motor_right   = speeds[1];
            r.motor_back    = speeds[2];
            r.motor_left    = speeds[3];
            r.running_count = COUNT_W'(cnt);
            expected_speeds.push_back(r);
        endfunction

        function void check_speeds(t_mix_out got);
            t_mix_out want;
            if (expected_speeds.size() == 0) begin
                errors++;
                if (errors <= 10) $display("%0t: unexpected result %p", $realtime, got);
                return;
            end
            want = expected_speeds.pop_front();
            if (got.motor_front !== want.motor_front || got.motor_right !== want.motor_right
                || got.motor_back !== want.motor_back || got.motor_left !== want.motor_left
                || got.running_count !== want.running_count) begin
                errors++;
                if (errors <= 10)
                    $display(
                        "%0t: mismatch expected %0d %0d %0d %0d %0d got %0d %0d %0d %0d %0d",
                        $realtime, want.motor_front, want.motor_right, want.motor_back,
                        want.motor_left, want.running_count, got.motor_front,
                        got.motor_right, got.motor_back, got.motor_left,
                        got.running_count);
            end
        endfunction
    endclass

    logic             i_clk;
    logic             i_rst_n     = 1'b0;
    logic             i_in_valid  = 1'b0;
    logic             o_in_stall;
    t_mix_in          i_in_data   = '0;
    logic             o_out_valid;
    logic             i_out_stall = 1'b0;
    t_mix_out         o_out_data;
    logic             i_cfg_valid = 1'b0;
    logic             o_cfg_ready;
    logic [0:0]       i_cfg_index = '0;
    logic [MIN_W-1:0] i_cfg_data  = '0;

    motor_speed_predictor mixer;
    int tx_idle_pct;
    int rx_idle_pct;
    bit long_hold_request;

    quad_motor_mixer_top dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #6 i_clk = ~i_clk;
    end

    initial begin
        #2_000_000;
        $display("FAILED: results differ");
        $finish;
    end

    // Result side: check accepted beats, then pick the stall for the next edge.
    initial begin
        int hold_left;
        hold_left = 0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n && o_out_valid && !i_out_stall) mixer.check_speeds(o_out_data);
            if (long_hold_request) begin
                long_hold_request = 1'b0;
                hold_left = 300;
            end
            if (hold_left > 0) begin
                hold_left--;
                i_out_stall <= 1'b1;
            end else begin
                i_out_stall <= ($urandom_range(99) < rx_idle_pct);
            end
        end
    end

    task automatic send_command(t_mix_in c);
        if ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            repeat ($urandom_range(1, 3)) @(posedge i_clk);
        end
        i_in_valid <= 1'b1;
        i_in_data  <= c;
        do @(posedge i_clk); while (o_in_stall);
        mixer.take_command(c);
    endtask

    // Lower valid and wait until every predicted beat has come back.
    task automatic drain();
        i_in_valid <= 1'b0;
        while (mixer.pending() != 0) @(posedge i_clk);
    endtask

    task automatic write_register(t_cfg_index idx, logic [MIN_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_index <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
        i_cfg_valid <= 1'b0;
        mixer.set_register(idx, val);
    endtask

    function automatic t_mix_in mk(logic k, int lift, int pitch, int roll, int yaw, int amt);
        t_mix_in c;
        c.kind        = k;
        c.lift        = STICK_W'(lift);
        c.pitch       = STICK_W'(pitch);
        c.roll        = STICK_W'(roll);
        c.yaw         = STICK_W'(yaw);
        c.ramp_amount = SPEED_W'(amt);
        return c;
    endfunction

    function automatic logic [STICK_W-1:0] pick_stick();
        case ($urandom_range(5))
            0: return 8'd0;
            1: return 8'd255;
            2: return C_STICK_CENTRE;
            3: return STICK_W'($urandom_range(120, 134));
            default: return STICK_W'($urandom_range(255));
        endcase
    endfunction

    function automatic t_mix_in pick_command();
        t_mix_in c;
        c.kind  = ($urandom_range(99) < 70) ? KIND_MANUAL : KIND_RAMP;
        case ($urandom_range(4))
            0: c.lift = '0;
            1: c.lift = 8'd255;
            default: c.lift = STICK_W'($urandom_range(255));
        endcase
        c.pitch = pick_stick();
        c.roll  = pick_stick();
        c.yaw   = pick_stick();
        case ($urandom_range(3))
            0: c.ramp_amount = SPEED_W'($urandom_range(2047));
            1: c.ramp_amount = 11'd2047;
            default: c.ramp_amount = SPEED_W'($urandom_range(64));
        endcase
        return c;
    endfunction

    initial begin
        int min_tab   [6];
        int shift_tab [6];
        mixer = new();
        mixer.clear();
        tx_idle_pct = 0;
        rx_idle_pct = 0;
        long_hold_request = 1'b0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed beats at reset configuration.
        send_command(mk(KIND_MANUAL, 0, 127, 127, 127, 0));
        send_command(mk(KIND_MANUAL, 100, 127, 127, 127, 0));
        send_command(mk(KIND_MANUAL, 255, 255, 255, 255, 0));
        send_command(mk(KIND_MANUAL, 255, 0, 0, 0, 2047));
        send_command(mk(KIND_MANUAL, 1, 128, 127, 127, 0));
        send_command(mk(KIND_MANUAL, 1, 126, 127, 127, 0));
        send_command(mk(KIND_MANUAL, 50, 127, 255, 127, 0));
        send_command(mk(KIND_MANUAL, 50, 127, 0, 127, 0));
        send_command(mk(KIND_MANUAL, 50, 127, 127, 255, 0));
        send_command(mk(KIND_MANUAL, 50, 127, 127, 0, 0));
        send_command(mk(KIND_RAMP, 0, 0, 0, 0, 0));
        send_command(mk(KIND_RAMP, 255, 255, 255, 255, 100));
        send_command(mk(KIND_RAMP, 0, 0, 0, 0, 2047));
        send_command(mk(KIND_MANUAL, 0, 255, 0, 255, 2047));
        drain();

        // Zero floor lets subtraction reach zero; full floor reaches the highest speed the mixer can give.
        write_register(CFG_FLOOR_SPEED, 9'd0);
        send_command(mk(KIND_MANUAL, 1, 0, 0, 0, 0));
        send_command(mk(KIND_MANUAL, 255, 0, 255, 0, 0));
        send_command(mk(KIND_MANUAL, 10, 255, 0, 127, 0));
        send_command(mk(KIND_RAMP, 0, 0, 0, 0, 5));
        drain();
        write_register(CFG_FLOOR_SPEED, 9'd511);
        send_command(mk(KIND_MANUAL, 255, 255, 255, 255, 0));
        send_command(mk(KIND_MANUAL, 255, 0, 255, 255, 0));
        send_command(mk(KIND_RAMP, 0, 0, 0, 0, 1000));
        send_command(mk(KIND_RAMP, 0, 0, 0, 0, 1));
        drain();

        min_tab   = '{511, 0, 0, 300, 180, 0};
        shift_tab = '{7, 7, 0, 3, 0, 0};
        min_tab[5]   = $urandom_range(511);
        shift_tab[5] = $urandom_range(7);
        for (int ph = 0; ph < 6; ph++) begin
            tx_idle_pct = (ph < 2) ? 28 : (ph < 4) ? 84 : 0;
            rx_idle_pct = (ph < 2) ? 84 : (ph < 4) ? 28 : 0;
            write_register(CFG_FLOOR_SPEED, MIN_W'(min_tab[ph]));
            write_register(CFG_STICK_SHIFT, MIN_W'(shift_tab[ph]));
            // Stall the result side long enough to back the pipe up into the input.
            if (ph == 4) long_hold_request = 1'b1;
            for (int n = 0; n < 64; n++) send_command(pick_command());
            drain();
        end

        repeat (8) @(posedge i_clk);
        if (mixer.errors == 0 && mixer.pending() == 0) begin
            $display("PASSED: all results match");
        end else begin
            $display("FAILED: results differ");
        end
        $finish;
    end

endmodule
